@@ rtl/core/fcr_pkg.sv @@
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared constants, types and the pixel fade function of the code rain core.
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam int WidthDef  = 16;
  localparam int HeightDef = 16;

  localparam int PixW = 24;
  localparam int ChW  = 8;

  localparam logic [PixW-1:0] TrailColor   = 24'h1B8227;
  localparam logic [PixW-1:0] HeadColorRst = 24'h00FF00;
  localparam logic [ChW-1:0]  FadeMul      = 8'd193;
  localparam logic [ChW-1:0]  ChFull       = 8'hFF;

  typedef struct packed {
    logic            valid;
    logic [PixW-1:0] pixel;
    logic            frame_done;
  } fcr_result_t;

  function automatic logic [ChW-1:0] fade_ch(input logic [ChW-1:0] c);
    logic [2*ChW-1:0] prod;
    prod = c * FadeMul;
    return prod[2*ChW-1:ChW];
  endfunction

  function automatic logic [PixW-1:0] fade_pixel(input logic [PixW-1:0] p);
    return {fade_ch(p[23:16]), fade_ch(p[15:8]), fade_ch(p[7:0])};
  endfunction

endpackage

@@ rtl/core/fcr_fb_mem.sv @@
// ----------------------------------------------------------------------------
// fcr_fb_mem
// Frame buffer: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module fcr_fb_mem #(
  parameter int Depth = fcr_pkg::WidthDef * fcr_pkg::HeightDef,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [fcr_pkg::PixW-1:0] wdata_i,
  input  logic [AddrW-1:0]         raddr_a_i,
  output logic [fcr_pkg::PixW-1:0] rdata_a_o,
  input  logic [AddrW-1:0]         raddr_b_i,
  output logic [fcr_pkg::PixW-1:0] rdata_b_o
);

  logic [fcr_pkg::PixW-1:0] mem_q [0:Depth-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/core/fcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcr_ctrl
// Sequencer: clearing pass, fused move/fade scan, spawn write and pixel read.
// ----------------------------------------------------------------------------
module fcr_ctrl #(
  parameter int Width  = fcr_pkg::WidthDef,
  parameter int Height = fcr_pkg::HeightDef,
  parameter int Depth  = Width * Height,
  parameter int AddrW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [fcr_pkg::PixW-1:0] head_color_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic [3:0]               spawn_col_i,
  input  logic [3:0]               read_col_i,
  input  logic [3:0]               read_row_i,
  output fcr_pkg::fcr_result_t     res_o,
  input  logic                     res_take_i,
  output logic                     mem_we_o,
  output logic [AddrW-1:0]         mem_waddr_o,
  output logic [fcr_pkg::PixW-1:0] mem_wdata_o,
  output logic [AddrW-1:0]         mem_raddr_a_o,
  input  logic [fcr_pkg::PixW-1:0] mem_rdata_a_i,
  output logic [AddrW-1:0]         mem_raddr_b_o,
  input  logic [fcr_pkg::PixW-1:0] mem_rdata_b_i
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StSpawn = 3'd4;
  localparam logic [2:0] StRead  = 3'd5;
  localparam logic [2:0] StResp  = 3'd6;

  localparam logic [AddrW-1:0] LastIdx   = AddrW'(Depth - 1);
  localparam logic [AddrW-1:0] BelowLim  = AddrW'(Depth - Width);
  localparam logic [AddrW-1:0] RowStep   = AddrW'(Width);
  localparam logic [AddrW-1:0] SpawnBase = AddrW'((Height - 1) * Width);

  logic [2:0]               state_q, state_d;
  logic [AddrW-1:0]         idx_q, idx_d;
  logic                     p1_valid_q;
  logic                     p1_below_q;
  logic [AddrW-1:0]         p1_addr_q;
  logic [AddrW-1:0]         spawn_addr_q;
  logic                     spawn_ok_q;
  logic [AddrW-1:0]         rd_addr_q;
  logic                     rd_ok_q;
  logic [fcr_pkg::PixW-1:0] res_pix_q, res_pix_d;
  logic                     res_frame_q, res_frame_d;
  logic                     in_accept;
  logic [AddrW-1:0]         rd_addr;
  logic                     rd_ok;
  logic                     below;
  logic [fcr_pkg::PixW-1:0] moved_pix;
  logic [fcr_pkg::PixW-1:0] new_pix;

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;

  assign rd_ok   = (32'(read_col_i) < Width) && (32'(read_row_i) < Height);
  assign rd_addr = AddrW'(32'(read_row_i) * Width + 32'(read_col_i));
  assign below   = (idx_q < BelowLim);

  assign mem_raddr_a_o = (state_q == StScan) ? idx_q :
                         ((state_q == StIdle) ? rd_addr : rd_addr_q);
  assign mem_raddr_b_o = idx_q + RowStep;

  always_comb begin
    if (p1_below_q && (mem_rdata_b_i == head_color_i)) begin
      moved_pix = head_color_i;
    end else if (mem_rdata_a_i == head_color_i) begin
      moved_pix = fcr_pkg::TrailColor;
    end else begin
      moved_pix = mem_rdata_a_i;
    end
    if (moved_pix[15:8] != fcr_pkg::ChFull) begin
      new_pix = fcr_pkg::fade_pixel(moved_pix);
    end else begin
      new_pix = moved_pix;
    end
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = p1_addr_q;
    mem_wdata_o = new_pix;
    if (state_q == StClear) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = idx_q;
      mem_wdata_o = '0;
    end else if (p1_valid_q) begin
      mem_we_o = 1'b1;
    end else if (state_q == StSpawn) begin
      mem_we_o    = spawn_ok_q;
      mem_waddr_o = spawn_addr_q;
      mem_wdata_o = head_color_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    res_pix_d   = res_pix_q;
    res_frame_d = res_frame_q;
    case (state_q)
      StClear: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_accept) begin
          idx_d   = '0;
          state_d = op_i ? StRead : StScan;
        end
      end
      StScan: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StSpawn;
      end
      StSpawn: begin
        res_pix_d   = '0;
        res_frame_d = 1'b1;
        state_d     = StResp;
      end
      StRead: begin
        res_pix_d   = rd_ok_q ? mem_rdata_a_i : '0;
        res_frame_d = 1'b0;
        state_d     = StResp;
      end
      StResp: begin
        if (res_take_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      idx_q      <= '0;
      p1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      p1_valid_q <= (state_q == StScan);
    end
  end

  always_ff @(posedge clk_i) begin
    p1_below_q  <= below;
    p1_addr_q   <= idx_q;
    res_pix_q   <= res_pix_d;
    res_frame_q <= res_frame_d;
    if (in_accept) begin
      spawn_addr_q <= SpawnBase + AddrW'(spawn_col_i);
      spawn_ok_q   <= (32'(spawn_col_i) < Width);
      rd_addr_q    <= rd_addr;
      rd_ok_q      <= rd_ok;
    end
  end

  assign res_o.valid      = (state_q == StResp);
  assign res_o.pixel      = res_pix_q;
  assign res_o.frame_done = res_frame_q;

  a_we_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q != StIdle && state_q != StResp && state_q != StRead))
    else $error("frame buffer written outside a pass");

  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == StScan || state_q == StRead))
    else $error("accepted beat did not start work");

  a_scan_then_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |=> (p1_valid_q && mem_we_o))
    else $error("scan read without write back");

  a_result_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !in_ready_o)
    else $error("input taken while result pending in sequencer");

endmodule

@@ rtl/core/falling_code_rain_frame_step_core.sv @@
// ----------------------------------------------------------------------------
// falling_code_rain_frame_step_core
// Code rain frame buffer: frame tick animates, read beat returns one pixel.
//
// channel   | dir | beat content
// s_axis    | in  | tuser[0] op; tdata spawn_col, read_col, read_row
// m_axis    | out | tdata pixel_color; tuser[0] frame_done
// cfg       | in  | cfg_data_i head_color
//
// Frame tick: one pixel per cycle through the single buffer write port, then
// the spawn write. After reset a clearing pass holds s_axis_tready low.
// A stalled m_axis holds its beat; the next input beat is still taken.
// ----------------------------------------------------------------------------
module falling_code_rain_frame_step_core #(
  parameter int WIDTH  = fcr_pkg::WidthDef,
  parameter int HEIGHT = fcr_pkg::HeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // spawn_col[3:0], read_col[7:4], read_row[11:8]
  input  logic [0:0]  s_axis_tuser,   // op[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // pixel_color[23:0]
  output logic [0:0]  m_axis_tuser,   // frame_done[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i
);

  localparam int Depth = WIDTH * HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [fcr_pkg::PixW-1:0] head_color_q;
  fcr_pkg::fcr_result_t     res;
  logic                     res_take;
  logic                     out_valid_q;
  logic [fcr_pkg::PixW-1:0] out_pix_q;
  logic                     out_done_q;

  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr;
  logic [fcr_pkg::PixW-1:0] mem_wdata;
  logic [AddrW-1:0]         mem_raddr_a;
  logic [fcr_pkg::PixW-1:0] mem_rdata_a;
  logic [AddrW-1:0]         mem_raddr_b;
  logic [fcr_pkg::PixW-1:0] mem_rdata_b;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_color_q <= fcr_pkg::HeadColorRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      head_color_q <= cfg_data_i;
    end
  end

  fcr_fb_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .rdata_a_o (mem_rdata_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_b_o (mem_rdata_b)
  );

  fcr_ctrl #(
    .Width  (WIDTH),
    .Height (HEIGHT),
    .Depth  (Depth),
    .AddrW  (AddrW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_color_i  (head_color_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tuser[0]),
    .spawn_col_i   (s_axis_tdata[3:0]),
    .read_col_i    (s_axis_tdata[7:4]),
    .read_row_i    (s_axis_tdata[11:8]),
    .res_o         (res),
    .res_take_i    (res_take),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_b_i (mem_rdata_b)
  );

  assign res_take = res.valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_pix_q  <= res.pixel;
      out_done_q <= res.frame_done;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_pix_q;
  assign m_axis_tuser[0] = out_done_q;

  a_take_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |-> (!out_valid_q || m_axis_tready))
    else $error("result overwrote an unsent beat");

  a_beat_from_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res.valid))
    else $error("output beat without sequencer result");

  a_frame_zero_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("frame tick beat carries pixel data");

endmodule

@@ tb/tb_falling_code_rain_frame_step_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_falling_code_rain_frame_step_core
// Self-checking bench for the code rain frame step core. A local model of the
// frame buffer predicts every output beat: frame ticks move heads one row
// down, leave trails, fade and spawn; read beats return one pixel. Stimulus
// is bursty with random receiver stalls, one long receiver hold-off, and
// head color changes (extremes included) between idle phases.
// ----------------------------------------------------------------------------
module tb_falling_code_rain_frame_step_core;

  localparam int Cols = fcr_pkg::WidthDef;
  localparam int Rows = fcr_pkg::HeightDef;
  localparam int PixW = fcr_pkg::PixW;

  localparam logic OpFrame = 1'b0;
  localparam logic OpRead  = 1'b1;

  localparam int IdleLimit  = 4000;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 40;
  localparam int NumPhases  = 10;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_done;
  } rain_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // spawn_col[3:0], read_col[7:4], read_row[11:8]
  logic [0:0]  s_axis_tuser = '0;   // op[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // pixel_color[23:0]
  logic [0:0]  m_axis_tuser;        // frame_done[0]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [23:0] cfg_data_i = '0;

  logic [PixW-1:0] pixels_q [Rows*Cols];
  logic [PixW-1:0] head_color_q = fcr_pkg::HeadColorRst;
  rain_beat_t      pending_beats [$];
  int              mismatch_count = 0;
  int              idle_cycles = 0;
  int              burst_left = 0;
  int              hold_req_cnt = 0;
  int              hold_seen = 0;
  int              hold_left = 0;
  int              stall_seg_left = 0;
  logic [31:0]     stall_pat = '1;

  always #6 clk_i = ~clk_i;

  falling_code_rain_frame_step_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic logic [PixW-1:0] faded(input logic [PixW-1:0] p);
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    r = p[23:16] * 16'd193;
    g = p[15:8] * 16'd193;
    b = p[7:0] * 16'd193;
    return {r[15:8], g[15:8], b[15:8]};
  endfunction

  task automatic advance_frame(input logic [3:0] spawn);
    int idx;
    for (int row = 0; row < Rows; row++) begin
      for (int col = 0; col < Cols; col++) begin
        idx = row * Cols + col;
        if (pixels_q[idx] == head_color_q) begin
          pixels_q[idx] = fcr_pkg::TrailColor;
          if (row > 0) pixels_q[idx - Cols] = head_color_q;
        end
      end
    end
    for (int i = 0; i < Rows * Cols; i++) begin
      if (pixels_q[i][15:8] != 8'hFF) pixels_q[i] = faded(pixels_q[i]);
    end
    if (spawn < Cols) pixels_q[(Rows - 1) * Cols + spawn] = head_color_q;
  endtask

  initial begin
    for (int i = 0; i < Rows * Cols; i++) pixels_q[i] = '0;
  end

  // Predict on accepted input beats, check accepted output beats.
  always @(posedge clk_i) begin
    rain_beat_t want;
    logic [3:0] rc;
    logic [3:0] rr;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual pixel %h done %b",
                   $time, m_axis_tdata, m_axis_tuser[0]);
          mismatch_count++;
        end else begin
          want = pending_beats.pop_front();
          if (m_axis_tdata != want.pixel) begin
            $display("%0t: pixel_color mismatch, expected %h actual %h",
                     $time, want.pixel, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tuser[0] != want.frame_done) begin
            $display("%0t: frame_done mismatch, expected %b actual %b",
                     $time, want.frame_done, m_axis_tuser[0]);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) head_color_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        rc = s_axis_tdata[7:4];
        rr = s_axis_tdata[11:8];
        if (s_axis_tuser[0] == OpFrame) begin
          advance_frame(s_axis_tdata[3:0]);
          want = '{pixel: '0, frame_done: 1'b1};
        end else begin
          want.pixel = (rc < Cols && rr < Rows) ? pixels_q[rr * Cols + rc] : '0;
          want.frame_done = 1'b0;
        end
        pending_beats.push_back(want);
      end
    end
  end

  // Receiver: random stall segments, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_seg_left == 0) begin
        stall_seg_left = $urandom_range(4, 64);
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = $urandom;
          2: stall_pat = $urandom | $urandom;
          default: stall_pat = $urandom & $urandom;
        endcase
      end
      stall_seg_left--;
      m_axis_tready <= stall_pat[stall_seg_left % 32];
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("Regression FAIL");
    $finish;
  end

  // Enter and leave at a falling edge; tvalid stays high inside a burst.
  task automatic send_item(input logic op, input logic [3:0] spawn,
                           input logic [3:0] rc, input logic [3:0] rr);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, rr, rc, spawn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_head_color(input logic [PixW-1:0] color);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= color;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_clear_after_reset();
    send_item(OpRead, 4'd0, 4'd0, 4'd0);
    send_item(OpRead, 4'd15, 4'd15, 4'd15);
  endtask

  // One head spawned at column 0 falls to row 0, then turns into a trail.
  task automatic test_head_falls_to_bottom();
    send_item(OpFrame, 4'd0, 4'd0, 4'd0);
    send_item(OpRead, 4'd0, 4'd0, 4'd15);
    send_item(OpFrame, 4'd15, 4'd15, 4'd15);
    send_item(OpRead, 4'd0, 4'd0, 4'd14);
    for (int i = 0; i < 14; i++)
      send_item(OpFrame, 4'($urandom_range(1, 15)), 4'd0, 4'd0);
    send_item(OpRead, 4'd0, 4'd0, 4'd0);
    send_item(OpFrame, 4'd5, 4'd0, 4'd0);
    send_item(OpRead, 4'd0, 4'd0, 4'd0);
    send_item(OpRead, 4'd0, 4'd15, 4'd1);
  endtask

  task automatic test_random_phases();
    logic [PixW-1:0] color;
    logic [3:0]      spawned [$];
    logic [3:0]      rc;
    int              pick;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: color = 24'h000000;
        1: color = 24'hFFFFFF;
        2: color = fcr_pkg::TrailColor;
        3: color = 24'h123456;
        default: begin
          pick = $urandom_range(0, 3);
          if (pick == 0) color = 24'($urandom);
          else if (pick == 1) color = {8'($urandom), 8'hFF, 8'($urandom)};
          else color = fcr_pkg::HeadColorRst;
        end
      endcase
      write_head_color(color);
      spawned.delete();
      for (int i = 0; i < PhaseItems; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          rc = 4'($urandom);
          spawned.push_back(rc);
          if (spawned.size() > 6) void'(spawned.pop_front());
          send_item(OpFrame, rc, 4'($urandom), 4'($urandom));
        end else if (pick < 70 && spawned.size() > 0) begin
          rc = spawned[$urandom_range(0, spawned.size() - 1)];
          send_item(OpRead, 4'($urandom), rc, 4'($urandom));
        end else begin
          send_item(OpRead, 4'($urandom), 4'($urandom), 4'($urandom));
        end
      end
    end
  endtask

  // Hold the receiver off while reads keep coming, so the input stalls.
  task automatic test_output_backpressure();
    drain();
    hold_req_cnt++;
    for (int i = 0; i < 24; i++)
      send_item(OpRead, 4'($urandom), 4'($urandom), 4'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_clear_after_reset();
    test_head_falls_to_bottom();
    test_random_phases();
    test_output_backpressure();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
